[rtl/pwmr_pkg.sv]
// Shared types and constants for the PWM linear ramp generator.
package pwmr_pkg;

    localparam int COMPARE_BITS_DEF = 16;
    localparam int STEPS_BITS       = 12;
    localparam logic [STEPS_BITS-1:0] STEPS_RESET = 12'd100;

    localparam logic OP_TICK = 1'b0;
    localparam logic OP_CMD  = 1'b1;

    localparam logic signed [1:0] DIR_FWD     = 2'sb01;
    localparam logic signed [1:0] DIR_STOP    = 2'sb00;
    localparam logic signed [1:0] DIR_REV     = 2'sb11;
    localparam logic signed [1:0] DIR_INVALID = 2'sb10;

    typedef enum logic [1:0] {
        ST_IDLE,
        ST_CALC,
        ST_EMIT
    } state_t;

    typedef enum logic [1:0] {
        MD_IDLE,
        MD_MUL,
        MD_DIV,
        MD_DONE
    } md_phase_t;

endpackage

[rtl/pwmr_if.sv]
// Channel interfaces: input items, result items and the step count register.
interface pwmr_req_if #(parameter int CB = pwmr_pkg::COMPARE_BITS_DEF);
    logic              valid;
    logic              ready;
    logic              operation;
    logic signed [1:0] direction;
    logic [CB-1:0]     speed;

    modport source(output valid, operation, direction, speed, input ready);
    modport sink(input valid, operation, direction, speed, output ready);
endinterface

interface pwmr_rsp_if #(parameter int CB = pwmr_pkg::COMPARE_BITS_DEF);
    logic          valid;
    logic          ready;
    logic [CB-1:0] compare_value;
    logic          direction_pin;
    logic          in_motion;
    logic          ramping;

    modport source(output valid, compare_value, direction_pin, in_motion, ramping,
                   input ready);
    modport sink(input valid, compare_value, direction_pin, in_motion, ramping,
                 output ready);
endinterface

interface pwmr_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [pwmr_pkg::STEPS_BITS-1:0] data;

    modport source(output valid, data, input ready);
    modport sink(input valid, data, output ready);
endinterface

[rtl/pwm_linear_ramp_generator_core.sv]
// Top level: command and tick handling, ramp state and result register.
//
//   channel  dir  payload
//   req      in   operation, direction, speed
//   rsp      out  compare_value, direction_pin, in_motion, ramping
//   cfg      in   data (ramp step count)
//
// Commands, idle ticks and final ticks: result loaded in the accept cycle.
// Mid-ramp ticks: the serial multiply/divide unit computes the new level
// in ST_CALC; the result is loaded in ST_EMIT once the output is free.
// Reset clears the control and ramp state and rsp.valid; step count returns to 100.
// req is held off in ST_CALC/ST_EMIT and while a result waits unaccepted.
module pwm_linear_ramp_generator_core
    import pwmr_pkg::*;
#(
    parameter int COMPARE_BITS = COMPARE_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    pwmr_req_if.sink    req,
    pwmr_rsp_if.source  rsp,
    pwmr_cfg_if.sink    cfg
);

    localparam int CB = COMPARE_BITS;

    state_t                 state_reg, state_next;
    logic [CB-1:0]          present_reg, present_next;
    logic [CB-1:0]          start_reg, start_next;
    logic [CB-1:0]          target_reg, target_next;
    logic signed [CB:0]     diff_reg, diff_next;
    logic [STEPS_BITS-1:0]  step_reg, step_next;
    logic                   active_reg, active_next;
    logic                   dir_reg, dir_next;
    logic                   motion_reg, motion_next;
    logic [STEPS_BITS-1:0]  steps_reg;
    logic                   ov_reg, ov_next;
    logic [CB-1:0]          ocmp_reg, ocmp_next;
    logic                   odir_reg, odir_next;
    logic                   omot_reg, omot_next;
    logic                   oramp_reg, oramp_next;

    logic                   accept, out_free, out_load;
    logic [STEPS_BITS-1:0]  step_inc;
    logic                   finish, tick_calc;
    logic [CB-1:0]          cmd_target;
    logic [CB:0]            mag_full;
    logic                   md_start, md_done;
    logic [CB-1:0]          md_quot;

    assign out_free  = ~ov_reg | rsp.ready;
    assign req.ready = (state_reg == ST_IDLE) & out_free;
    assign accept    = req.valid & req.ready;
    assign step_inc  = step_reg + 1'b1;
    assign finish    = (steps_reg == '0) | (step_inc == '0) | (step_inc >= steps_reg);
    assign tick_calc = accept & (req.operation == OP_TICK) & active_reg & ~finish;
    assign md_start  = tick_calc;
    assign cmd_target = (req.direction == DIR_STOP) ? '0 : req.speed;
    assign mag_full  = diff_reg[CB] ? (~diff_reg + 1'b1) : diff_reg;

    assign cfg.ready         = 1'b1;
    assign rsp.valid         = ov_reg;
    assign rsp.compare_value = ocmp_reg;
    assign rsp.direction_pin = odir_reg;
    assign rsp.in_motion     = omot_reg;
    assign rsp.ramping       = oramp_reg;

    pwmr_muldiv #(
        .CB(CB)
    ) u_muldiv (
        .clk     (clk),
        .rst_n   (rst_n),
        .start   (md_start),
        .mag     (mag_full[CB-1:0]),
        .mult    (step_inc),
        .divisor (steps_reg),
        .done    (md_done),
        .quot    (md_quot)
    );

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (tick_calc)
                begin
                    state_next = ST_CALC;
                end
            end
            ST_CALC:
            begin
                if (md_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        present_next = present_reg;
        start_next   = start_reg;
        target_next  = target_reg;
        diff_next    = diff_reg;
        step_next    = step_reg;
        active_next  = active_reg;
        dir_next     = dir_reg;
        motion_next  = motion_reg;
        out_load     = 1'b0;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    if (req.operation == OP_CMD)
                    begin
                        out_load = 1'b1;
                        if (req.direction != DIR_INVALID)
                        begin
                            dir_next    = (req.direction == DIR_FWD);
                            motion_next = (req.direction != DIR_STOP);
                            if (cmd_target == present_reg)
                            begin
                                active_next = 1'b0;
                            end
                            else if (steps_reg == '0)
                            begin
                                present_next = cmd_target;
                                active_next  = 1'b0;
                            end
                            else
                            begin
                                start_next  = present_reg;
                                target_next = cmd_target;
                                diff_next   = $signed({1'b0, cmd_target})
                                            - $signed({1'b0, present_reg});
                                step_next   = '0;
                                active_next = 1'b1;
                            end
                        end
                    end
                    else if (active_reg)
                    begin
                        step_next = step_inc;
                        if (finish)
                        begin
                            present_next = target_reg;
                            active_next  = 1'b0;
                            out_load     = 1'b1;
                        end
                    end
                    else
                    begin
                        out_load = 1'b1;
                    end
                end
            end
            ST_CALC:
            begin
                if (md_done)
                begin
                    present_next = diff_reg[CB] ? (start_reg - md_quot)
                                                : (start_reg + md_quot);
                end
            end
            ST_EMIT:
            begin
                out_load = out_free;
            end
            default:
            begin
                out_load = 1'b0;
            end
        endcase
    end

    always_comb
    begin
        ov_next    = ov_reg;
        ocmp_next  = ocmp_reg;
        odir_next  = odir_reg;
        omot_next  = omot_reg;
        oramp_next = oramp_reg;
        if (out_load)
        begin
            ov_next    = 1'b1;
            ocmp_next  = present_next;
            odir_next  = dir_next;
            omot_next  = motion_next;
            oramp_next = active_next;
        end
        else if (rsp.ready)
        begin
            ov_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= ST_IDLE;
            present_reg <= '0;
            start_reg   <= '0;
            target_reg  <= '0;
            diff_reg    <= '0;
            step_reg    <= '0;
            active_reg  <= 1'b0;
            dir_reg     <= 1'b0;
            motion_reg  <= 1'b0;
            ov_reg      <= 1'b0;
        end
        else
        begin
            state_reg   <= state_next;
            present_reg <= present_next;
            start_reg   <= start_next;
            target_reg  <= target_next;
            diff_reg    <= diff_next;
            step_reg    <= step_next;
            active_reg  <= active_next;
            dir_reg     <= dir_next;
            motion_reg  <= motion_next;
            ov_reg      <= ov_next;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            steps_reg <= STEPS_RESET;
        end
        else if (cfg.valid)
        begin
            steps_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk)
    begin
        ocmp_reg  <= ocmp_next;
        odir_reg  <= odir_next;
        omot_reg  <= omot_next;
        oramp_reg <= oramp_next;
    end

endmodule

[rtl/pwmr_muldiv.sv]
// Serial shift-add multiply then restoring divide on one shared adder.
module pwmr_muldiv
    import pwmr_pkg::*;
#(
    parameter int CB = COMPARE_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  start,
    input  logic [CB-1:0]         mag,
    input  logic [STEPS_BITS-1:0] mult,
    input  logic [STEPS_BITS-1:0] divisor,
    output logic                  done,
    output logic [CB-1:0]         quot
);

    localparam int PW = CB + STEPS_BITS;
    localparam int AW = PW + 1;
    localparam int CW = $clog2(PW + 1);

    md_phase_t              phase_reg, phase_next;
    logic [CW-1:0]          cnt_reg, cnt_next;
    logic [PW-1:0]          acc_reg, acc_next;
    logic [PW-1:0]          mcand_reg, mcand_next;
    logic [STEPS_BITS-1:0]  mplier_reg, mplier_next;
    logic [STEPS_BITS-1:0]  div_reg, div_next;
    logic [STEPS_BITS-1:0]  rem_reg, rem_next;

    logic [AW-1:0]          add_a, add_b, sum;
    logic                   cin;
    logic [STEPS_BITS:0]    shifted;
    logic                   qbit;

    assign shifted = {rem_reg, acc_reg[PW-1]};
    assign sum     = add_a + add_b + AW'(cin);
    assign qbit    = ~sum[AW-1];
    assign done    = (phase_reg == MD_DONE);
    assign quot    = acc_reg[CB-1:0];

    always_comb
    begin
        phase_next = phase_reg;
        case (phase_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    phase_next = MD_MUL;
                end
            end
            MD_MUL:
            begin
                if (cnt_reg == '0)
                begin
                    phase_next = MD_DIV;
                end
            end
            MD_DIV:
            begin
                if (cnt_reg == '0)
                begin
                    phase_next = MD_DONE;
                end
            end
            MD_DONE:
            begin
                phase_next = MD_IDLE;
            end
            default:
            begin
                phase_next = MD_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cnt_next    = cnt_reg;
        acc_next    = acc_reg;
        mcand_next  = mcand_reg;
        mplier_next = mplier_reg;
        div_next    = div_reg;
        rem_next    = rem_reg;
        add_a       = '0;
        add_b       = '0;
        cin         = 1'b0;
        case (phase_reg)
            MD_IDLE:
            begin
                if (start)
                begin
                    acc_next    = '0;
                    mcand_next  = PW'(mag);
                    mplier_next = mult;
                    div_next    = divisor;
                    rem_next    = '0;
                    cnt_next    = CW'(STEPS_BITS - 1);
                end
            end
            MD_MUL:
            begin
                add_a       = AW'(acc_reg);
                add_b       = mplier_reg[0] ? AW'(mcand_reg) : '0;
                acc_next    = sum[PW-1:0];
                mcand_next  = {mcand_reg[PW-2:0], 1'b0};
                mplier_next = {1'b0, mplier_reg[STEPS_BITS-1:1]};
                cnt_next    = (cnt_reg == '0) ? CW'(PW - 1) : cnt_reg - 1'b1;
            end
            MD_DIV:
            begin
                add_a    = AW'(shifted);
                add_b    = ~AW'(div_reg);
                cin      = 1'b1;
                rem_next = qbit ? sum[STEPS_BITS-1:0] : shifted[STEPS_BITS-1:0];
                acc_next = {acc_reg[PW-2:0], qbit};
                cnt_next = cnt_reg - 1'b1;
            end
            default:
            begin
                cnt_next = cnt_reg;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= MD_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            phase_reg <= phase_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        acc_reg    <= acc_next;
        mcand_reg  <= mcand_next;
        mplier_reg <= mplier_next;
        div_reg    <= div_next;
        rem_reg    <= rem_next;
    end

endmodule

[tb/sv/testbench.sv]
// Self-checking testbench for the PWM linear ramp generator core.
module testbench;
    import pwmr_pkg::*;

    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic [15:0] cmp;
        logic        pin;
        logic        motion;
        logic        ramping;
    } ramp_out_t;

    typedef enum logic {
        ROW_ITEM,
        ROW_STEPS
    } row_kind_t;

    typedef struct packed {
        row_kind_t         kind;
        logic              op;
        logic signed [1:0] dir;
        logic [15:0]       arg;
        logic              typed;
        ramp_out_t         res;
    } plan_row_t;

    localparam ramp_out_t NO_RES = '0;
    localparam int PLAN_LEN = 31;
    localparam int HOLD_CYCLES = 300;
    localparam int PHASES = 8;

    // arg is the speed for items, the step count for register writes
    localparam plan_row_t DIRECTED_PLAN [PLAN_LEN] = '{
        '{ROW_ITEM,  OP_TICK, DIR_STOP,    16'd0,     1'b1, '{16'd0,     1'b0, 1'b0, 1'b0}},
        '{ROW_ITEM,  OP_CMD,  DIR_INVALID, 16'hFFFF,  1'b1, '{16'd0,     1'b0, 1'b0, 1'b0}},
        '{ROW_ITEM,  OP_CMD,  DIR_STOP,    16'd1234,  1'b1, '{16'd0,     1'b0, 1'b0, 1'b0}},
        '{ROW_ITEM,  OP_CMD,  DIR_FWD,     16'd0,     1'b1, '{16'd0,     1'b1, 1'b1, 1'b0}},
        '{ROW_ITEM,  OP_CMD,  DIR_REV,     16'd0,     1'b1, '{16'd0,     1'b0, 1'b1, 1'b0}},
        '{ROW_ITEM,  OP_CMD,  DIR_FWD,     16'hFFFF,  1'b1, '{16'd0,     1'b1, 1'b1, 1'b1}},
        '{ROW_ITEM,  OP_TICK, DIR_STOP,    16'd0,     1'b0, NO_RES},
        '{ROW_ITEM,  OP_TICK, DIR_FWD,     16'hFFFF,  1'b0, NO_RES},
        '{ROW_ITEM,  OP_CMD,  DIR_INVALID, 16'd0,     1'b0, NO_RES},
        '{ROW_ITEM,  OP_CMD,  DIR_REV,     16'd100,   1'b0, NO_RES},
        '{ROW_ITEM,  OP_TICK, DIR_STOP,    16'd0,     1'b0, NO_RES},
        '{ROW_STEPS, OP_TICK, DIR_STOP,    16'd2,     1'b0, NO_RES},
        '{ROW_ITEM,  OP_TICK, DIR_STOP,    16'd0,     1'b1, '{16'd100,   1'b0, 1'b1, 1'b0}},
        '{ROW_ITEM,  OP_TICK, DIR_STOP,    16'd0,     1'b1, '{16'd100,   1'b0, 1'b1, 1'b0}},
        '{ROW_ITEM,  OP_CMD,  DIR_FWD,     16'd100,   1'b1, '{16'd100,   1'b1, 1'b1, 1'b0}},
        '{ROW_ITEM,  OP_CMD,  DIR_STOP,    16'd0,     1'b1, '{16'd100,   1'b0, 1'b0, 1'b1}},
        '{ROW_STEPS, OP_TICK, DIR_STOP,    16'd0,     1'b0, NO_RES},
        '{ROW_ITEM,  OP_TICK, DIR_STOP,    16'd0,     1'b1, '{16'd0,     1'b0, 1'b0, 1'b0}},
        '{ROW_ITEM,  OP_CMD,  DIR_FWD,     16'hFFFF,  1'b1, '{16'hFFFF,  1'b1, 1'b1, 1'b0}},
        '{ROW_STEPS, OP_TICK, DIR_STOP,    16'd4095,  1'b0, NO_RES},
        '{ROW_ITEM,  OP_CMD,  DIR_REV,     16'd0,     1'b1, '{16'hFFFF,  1'b0, 1'b1, 1'b1}},
        '{ROW_ITEM,  OP_TICK, DIR_STOP,    16'd0,     1'b0, NO_RES},
        '{ROW_ITEM,  OP_TICK, DIR_STOP,    16'd0,     1'b0, NO_RES},
        '{ROW_STEPS, OP_TICK, DIR_STOP,    16'd1,     1'b0, NO_RES},
        '{ROW_ITEM,  OP_TICK, DIR_STOP,    16'd0,     1'b1, '{16'd0,     1'b0, 1'b1, 1'b0}},
        '{ROW_ITEM,  OP_CMD,  DIR_STOP,    16'd7,     1'b1, '{16'd0,     1'b0, 1'b0, 1'b0}},
        '{ROW_STEPS, OP_TICK, DIR_STOP,    16'd3,     1'b0, NO_RES},
        '{ROW_ITEM,  OP_CMD,  DIR_FWD,     16'hFFFF,  1'b0, NO_RES},
        '{ROW_ITEM,  OP_TICK, DIR_STOP,    16'd0,     1'b0, NO_RES},
        '{ROW_ITEM,  OP_TICK, DIR_STOP,    16'd0,     1'b0, NO_RES},
        '{ROW_ITEM,  OP_TICK, DIR_STOP,    16'd0,     1'b0, NO_RES}
    };

    logic clk;
    logic rst_n;

    pwmr_req_if req_ch ();
    pwmr_rsp_if rsp_ch ();
    pwmr_cfg_if cfg_ch ();

    pwm_linear_ramp_generator_core dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    // predicted block state
    logic [15:0]        pr_cmp;
    logic [15:0]        pr_start;
    logic signed [16:0] pr_diff;
    logic [15:0]        pr_target;
    logic [11:0]        pr_idx;
    logic               pr_active;
    logic               pr_pin;
    logic               pr_motion;
    logic [11:0]        pr_steps;

    ramp_out_t pending_outputs[$];
    int        err_count;
    int        src_idle_pct;
    int        snk_idle_pct;
    int        hold_requests;
    int        hold_served;
    int        hold_left;

    initial
    begin
        clk = 1'b0;
    end

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    task automatic flag_mismatch(input string what);
        if (err_count < 50)
            $display("%0t mismatch: %s", $realtime, what);
        err_count++;
    endtask

    function automatic ramp_out_t next_ramp_output(input logic op,
                                                   input logic signed [1:0] dir,
                                                   input logic [15:0] spd);
        logic [15:0] target;
        longint      part;
        longint      level;
        if (op == OP_CMD && dir != DIR_INVALID)
        begin
            pr_pin    = (dir == DIR_FWD);
            pr_motion = (dir != DIR_STOP);
            target    = (dir == DIR_STOP) ? 16'd0 : spd;
            if (target == pr_cmp)
                pr_active = 1'b0;
            else if (pr_steps == 0)
            begin
                pr_cmp    = target;
                pr_active = 1'b0;
            end
            else
            begin
                pr_start  = pr_cmp;
                pr_target = target;
                pr_diff   = 17'(int'(target) - int'(pr_cmp));
                pr_idx    = '0;
                pr_active = 1'b1;
            end
        end
        else if (op == OP_TICK && pr_active)
        begin
            pr_idx = pr_idx + 12'd1;
            if (pr_steps == 0 || pr_idx == 0 || pr_idx >= pr_steps)
            begin
                pr_cmp    = pr_target;
                pr_active = 1'b0;
            end
            else
            begin
                part  = longint'(pr_diff) * longint'(pr_idx) / longint'(pr_steps);
                level = longint'(pr_start) + part;
                if (level < 0)
                    level = 0;
                pr_cmp = level[15:0];
            end
        end
        return '{pr_cmp, pr_pin, pr_motion, pr_active};
    endfunction

    task automatic send_item(input logic op, input logic signed [1:0] dir,
                             input logic [15:0] spd, input logic typed,
                             input ramp_out_t typed_res);
        ramp_out_t predicted;
        if ($urandom_range(99) < src_idle_pct)
        begin
            req_ch.valid <= 1'b0;
            do @(posedge clk); while ($urandom_range(99) < src_idle_pct);
        end
        req_ch.valid     <= 1'b1;
        req_ch.operation <= op;
        req_ch.direction <= dir;
        req_ch.speed     <= spd;
        do @(posedge clk); while (!req_ch.ready);
        predicted = next_ramp_output(op, dir, spd);
        pending_outputs.push_back(typed ? typed_res : predicted);
    endtask

    task automatic wait_outputs_drained();
        req_ch.valid <= 1'b0;
        while (pending_outputs.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_steps(input logic [11:0] value);
        wait_outputs_drained();
        repeat (50) @(posedge clk);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= value;
        do @(posedge clk); while (!cfg_ch.ready);
        cfg_ch.valid <= 1'b0;
        pr_steps = value;
    endtask

    // command followed by a run of ticks, with some invalid commands mixed in
    task automatic random_ramps(input int goal);
        int                sent;
        int                ticks;
        int                cap;
        logic signed [1:0] dir;
        logic [15:0]       spd;
        sent = 0;
        while (sent < goal)
        begin
            if ($urandom_range(99) < 8)
            begin
                send_item(OP_CMD, DIR_INVALID, 16'($urandom), 1'b0, NO_RES);
                sent++;
            end
            else
            begin
                case ($urandom_range(9))
                    0, 1, 2, 3: dir = DIR_FWD;
                    4, 5, 6:    dir = DIR_REV;
                    default:    dir = DIR_STOP;
                endcase
                case ($urandom_range(9))
                    0:       spd = pr_cmp;
                    1:       spd = 16'hFFFF;
                    2:       spd = 16'd0;
                    default: spd = 16'($urandom);
                endcase
                send_item(OP_CMD, dir, spd, 1'b0, NO_RES);
                sent++;
                cap   = (pr_steps < 30) ? int'(pr_steps) : 30;
                ticks = $urandom_range(cap + 2);
                repeat (ticks)
                begin
                    send_item(OP_TICK, 2'($urandom), 16'($urandom), 1'b0, NO_RES);
                    sent++;
                end
            end
        end
    endtask

    // receiver: random stalls, plus one long hold-off on request
    always @(posedge clk)
    begin
        if (hold_requests != hold_served)
        begin
            hold_served  <= hold_requests;
            hold_left    <= HOLD_CYCLES;
            rsp_ch.ready <= 1'b0;
        end
        else if (hold_left > 0)
        begin
            hold_left    <= hold_left - 1;
            rsp_ch.ready <= 1'b0;
        end
        else
            rsp_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end

    always @(posedge clk)
    begin : result_check
        ramp_out_t want;
        if (rst_n && rsp_ch.valid && rsp_ch.ready)
        begin
            if (pending_outputs.size() == 0)
                flag_mismatch("result item with nothing expected");
            else
            begin
                want = pending_outputs.pop_front();
                if (rsp_ch.compare_value !== want.cmp)
                    flag_mismatch($sformatf("compare_value got %0d want %0d",
                                            rsp_ch.compare_value, want.cmp));
                if (rsp_ch.direction_pin !== want.pin)
                    flag_mismatch($sformatf("direction_pin got %b want %b",
                                            rsp_ch.direction_pin, want.pin));
                if (rsp_ch.in_motion !== want.motion)
                    flag_mismatch($sformatf("in_motion got %b want %b",
                                            rsp_ch.in_motion, want.motion));
                if (rsp_ch.ramping !== want.ramping)
                    flag_mismatch($sformatf("ramping got %b want %b",
                                            rsp_ch.ramping, want.ramping));
            end
        end
    end

    initial
    begin
        #(20_000_000);
        $display("RESULT: ERROR");
        $finish;
    end

    initial
    begin
        int          ph;
        logic [11:0] phase_steps [PHASES];
        phase_steps = '{12'd5, 12'd1, 12'd17, 12'd0, 12'd4095, 12'd2, 12'd9,
                        12'($urandom_range(40, 3))};

        rst_n            = 1'b0;
        req_ch.valid     = 1'b0;
        req_ch.operation = OP_TICK;
        req_ch.direction = DIR_STOP;
        req_ch.speed     = '0;
        rsp_ch.ready     = 1'b0;
        cfg_ch.valid     = 1'b0;
        cfg_ch.data      = '0;
        err_count        = 0;
        hold_requests    = 0;
        hold_served      = 0;
        hold_left        = 0;
        src_idle_pct     = 24;
        snk_idle_pct     = 56;
        pr_cmp           = '0;
        pr_start         = '0;
        pr_diff          = '0;
        pr_target        = '0;
        pr_idx           = '0;
        pr_active        = 1'b0;
        pr_pin           = 1'b0;
        pr_motion        = 1'b0;
        pr_steps         = STEPS_RESET;

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (DIRECTED_PLAN[i])
        begin
            if (DIRECTED_PLAN[i].kind == ROW_STEPS)
                write_steps(DIRECTED_PLAN[i].arg[11:0]);
            else
                send_item(DIRECTED_PLAN[i].op, DIRECTED_PLAN[i].dir, DIRECTED_PLAN[i].arg,
                          DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].res);
        end

        for (ph = 0; ph < PHASES; ph++)
        begin
            if (ph == 3)
            begin
                src_idle_pct = 56;
                snk_idle_pct = 24;
            end
            if (ph == 6)
            begin
                src_idle_pct = 0;
                snk_idle_pct = 0;
            end
            write_steps(phase_steps[ph]);
            if (ph == 6)
                hold_requests <= hold_requests + 1;
            if (ph == 7)
            begin
                random_ramps(80);
                wait_outputs_drained();
                random_ramps(75);
            end
            else
                random_ramps(155);
        end

        wait_outputs_drained();
        repeat (60) @(posedge clk);
        if (pending_outputs.size() != 0)
            flag_mismatch("expected result items never arrived");
        if (err_count == 0)
            $display("RESULT: OK");
        else
            $display("RESULT: ERROR");
        $finish;
    end

endmodule

[files.f]
rtl/pwmr_pkg.sv
rtl/pwmr_if.sv
rtl/pwmr_muldiv.sv
rtl/pwm_linear_ramp_generator_core.sv
tb/sv/testbench.sv
